// ----- sv/drhf_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// distance relevancy hysteresis filter. No dependencies.
`timescale 1ns / 1ps
package drhf_pkg;

  localparam int MAX_ANCHORS  = 4;
  localparam int MAX_CLIENTS  = 4;
  localparam int MAX_ENTITIES = 1024;
  localparam int COORD_BITS   = 20;

  localparam int ANC_W    = $clog2(MAX_ANCHORS);
  localparam int CNT_W    = $clog2(MAX_ANCHORS + 1);
  localparam int CLI_W    = 2;
  localparam int ENT_W    = 10;
  localparam int SLOT_W   = CLI_W + ENT_W;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int RAD_W    = 20;
  localparam int ROUT_W   = RAD_W + 1;
  localparam int DWELL_W  = 16;
  localparam int TICK_W   = 32;
  localparam int ENTRY_W  = TICK_W + 1;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;

  localparam logic [RAD_W-1:0] DEFAULT_RADIUS = RAD_W'(3840);
  localparam logic [RAD_W-1:0] RESET_EXIT     = RAD_W'(4800);
  localparam logic [DWELL_W-1:0] RESET_DWELL  = DWELL_W'(30);

  // op codes carried on in_tuser
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_ANCHOR = 2'd1;
  localparam logic [1:0] OP_CAND   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ENTER = 2'd0;
  localparam logic [1:0] REG_EXIT  = 2'd1;
  localparam logic [1:0] REG_DWELL = 2'd2;

  typedef struct packed {
    logic clr;        // write one zero entry of the clearing pass
    logic accept;     // input transfer this cycle
    logic sq;         // square the per-axis differences for one anchor
    logic acc;        // sum and keep the minimum
    logic rad;        // square the effective radii
    logic emit_quick; // load an unfiltered result
    logic emit_dec;   // load the filtered decision and update the table
  } drhf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_cand_full;  // incoming candidate needs the distance path
    logic in_cand_quick; // incoming candidate gives an unfiltered result
    logic last_anchor;
    logic out_free;
  } drhf_sts_t;

endpackage

// ----- sv/drhf_ctrl.sv -----
// Sequencer of the relevancy filter: clearing pass, item intake, anchor loop
// and result hand-off. Depends on drhf_pkg.
`timescale 1ns / 1ps
module drhf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  drhf_pkg::drhf_sts_t sts,
  output drhf_pkg::drhf_cmd_t cmd
);
  import drhf_pkg::*;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_QUICK, S_SQ, S_ACC, S_RAD, S_DEC} state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (sts.in_cand_full) state_nxt = S_SQ;
          else if (sts.in_cand_quick) state_nxt = S_QUICK;
        end
      end
      S_QUICK: begin
        if (sts.out_free) begin
          cmd.emit_quick = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_anchor ? S_RAD : S_SQ;
      end
      S_RAD: begin
        cmd.rad   = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.out_free) begin
          cmd.emit_dec = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

endmodule

// ----- sv/drhf_dp.sv -----
// Datapath of the relevancy filter: configuration, anchor registers, distance
// unit, membership table and result register. Depends on drhf_pkg.
`timescale 1ns / 1ps
module drhf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [19:0]                   cfg_wdata,
  input  logic [drhf_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [drhf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  drhf_pkg::drhf_cmd_t           cmd,
  output drhf_pkg::drhf_sts_t           sts
);
  import drhf_pkg::*;

  // input field split
  logic [CLI_W-1:0]      f_client;
  logic [TICK_W-1:0]     f_tick;
  logic [ENT_W-1:0]      f_entity;
  logic                  f_found, f_haspos;
  logic [COORD_BITS-1:0] f_x, f_y, f_z;
  assign f_client = in_tdata[1:0];
  assign f_tick   = in_tdata[33:2];
  assign f_entity = in_tdata[43:34];
  assign f_found  = in_tdata[44];
  assign f_haspos = in_tdata[45];
  assign f_x      = in_tdata[65:46];
  assign f_y      = in_tdata[85:66];
  assign f_z      = in_tdata[105:86];

  // configuration registers
  logic [RAD_W-1:0]   enter_r, exit_r;
  logic [DWELL_W-1:0] dwell_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_r <= DEFAULT_RADIUS;
      exit_r  <= RESET_EXIT;
      dwell_r <= RESET_DWELL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTER: enter_r <= cfg_wdata;
        REG_EXIT:  exit_r  <= cfg_wdata;
        REG_DWELL: dwell_r <= cfg_wdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // query context and anchors
  logic [CLI_W-1:0]  client_r;
  logic [TICK_W-1:0] tick_r;
  logic [CNT_W-1:0]  count_r;
  logic [3*COORD_BITS-1:0] anc_r [MAX_ANCHORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_r <= '0;
      tick_r   <= '0;
      count_r  <= '0;
    end else if (cmd.accept) begin
      if (in_tuser == OP_BEGIN) begin
        client_r <= f_client;
        tick_r   <= f_tick;
        count_r  <= '0;
      end else if (in_tuser == OP_ANCHOR && f_haspos && count_r < CNT_W'(MAX_ANCHORS)) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_tuser == OP_ANCHOR && f_haspos && count_r < CNT_W'(MAX_ANCHORS))
      anc_r[count_r[ANC_W-1:0]] <= {f_z, f_y, f_x};
  end

  // candidate latch
  logic [ENT_W-1:0]      ent_r;
  logic [COORD_BITS-1:0] cx_r, cy_r, cz_r;
  logic [SLOT_W-1:0]     slot_r;
  always_ff @(posedge clk) begin
    if (cmd.accept && in_tuser == OP_CAND) begin
      ent_r  <= f_entity;
      cx_r   <= f_x;
      cy_r   <= f_y;
      cz_r   <= f_z;
      slot_r <= {client_r, f_entity};
    end
  end

  logic cnt_zero;
  assign cnt_zero = (count_r == '0);
  assign sts.in_cand_full  = (in_tuser == OP_CAND) && !cnt_zero && f_found && f_haspos;
  assign sts.in_cand_quick = (in_tuser == OP_CAND) && (cnt_zero || (f_found && !f_haspos));

  // anchor loop: for each anchor, three squares then a sum
  logic [ANC_W-1:0] idx_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r, near_r;
  logic [3*COORD_BITS-1:0] anc_sel;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [DIFF_W-1:0] ax, ay, az;
  logic [SQ_W-1:0] dsum;

  assign anc_sel = anc_r[idx_r];
  assign dx = DIFF_W'($signed(cx_r)) - DIFF_W'($signed(anc_sel[COORD_BITS-1:0]));
  assign dy = DIFF_W'($signed(cy_r)) - DIFF_W'($signed(anc_sel[2*COORD_BITS-1:COORD_BITS]));
  assign dz = DIFF_W'($signed(cz_r)) - DIFF_W'($signed(anc_sel[3*COORD_BITS-1:2*COORD_BITS]));
  assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
  assign dsum = sqx_r + sqy_r + sqz_r;
  assign sts.last_anchor = ({1'b0, idx_r} == CNT_W'(count_r - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r  <= '0;
      near_r <= '1;
    end
    if (cmd.sq) begin
      sqx_r <= ax * ax;
      sqy_r <= ay * ay;
      sqz_r <= az * az;
    end
    if (cmd.acc) begin
      if (dsum < near_r) near_r <= dsum;
      idx_r <= idx_r + ANC_W'(1);
    end
  end

  // effective radii, squared
  logic [RAD_W-1:0]  r_in;
  logic [ROUT_W-1:0] r_out;
  logic [SQ_W-1:0]   enter_sq_r, exit_sq_r;
  assign r_in  = (enter_r == '0) ? DEFAULT_RADIUS : enter_r;
  assign r_out = (exit_r <= r_in) ? (ROUT_W'(r_in) + ROUT_W'(r_in >> 2)) : ROUT_W'(exit_r);
  always_ff @(posedge clk) begin
    if (cmd.rad) begin
      enter_sq_r <= SQ_W'(r_in * r_in);
      exit_sq_r  <= SQ_W'(r_out * r_out);
    end
  end

  // membership table with clearing sweep
  logic [ENTRY_W-1:0] pair_mem [MAX_CLIENTS*MAX_ENTITIES];
  logic [ENTRY_W-1:0] rd_r, wr_entry;
  logic [SLOT_W-1:0]  clr_addr_r;
  logic               dec_inc;

  assign sts.clr_last = (clr_addr_r == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr) clr_addr_r <= clr_addr_r + SLOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) pair_mem[clr_addr_r] <= '0;
    else if (cmd.emit_dec) pair_mem[slot_r] <= wr_entry;
    rd_r <= pair_mem[slot_r];
  end

  // hysteresis and dwell decision
  logic [TICK_W-1:0] next_tick, since, age;
  logic              member;
  assign member    = rd_r[ENTRY_W-1];
  assign since     = rd_r[TICK_W-1:0];
  assign next_tick = tick_r + TICK_W'(1);
  assign age       = next_tick - since;

  always_comb begin
    wr_entry = rd_r;
    dec_inc  = 1'b1;
    if (!member) begin
      if (near_r <= enter_sq_r) wr_entry = {1'b1, {TICK_W{1'b0}}};
      else dec_inc = 1'b0;
    end else if (near_r <= exit_sq_r) begin
      wr_entry = {1'b1, {TICK_W{1'b0}}};
    end else if (since == '0) begin
      wr_entry = {1'b1, next_tick};
    end else if (age >= TICK_W'(dwell_r)) begin
      wr_entry = '0;
      dec_inc  = 1'b0;
    end
  end

  // result register
  logic       out_valid_r;
  logic [ENT_W-1:0] out_ent_r;
  logic       out_inc_r, out_unf_r;
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit_quick || cmd.emit_dec) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_quick) begin
      out_ent_r <= ent_r;
      out_inc_r <= 1'b1;
      out_unf_r <= 1'b1;
    end else if (cmd.emit_dec) begin
      out_ent_r <= ent_r;
      out_inc_r <= dec_inc;
      out_unf_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_unf_r, out_inc_r, out_ent_r};

endmodule

// ----- sv/distance_relevancy_hysteresis_filter.sv -----
// Top level of the distance relevancy hysteresis filter: sequencer plus
// datapath. Depends on drhf_pkg, drhf_ctrl, drhf_dp.
//
// Use: items arrive on the in_ stream, op on in_tuser. A begin transfer sets
// client and tick and empties the anchor list; anchor transfers add up to four
// positions; a candidate transfer gives one result on the out_ stream unless
// anchors exist and the entity is not live.
// Per item: begin, anchor and dropped candidates are taken in the idle state;
// an unfiltered candidate then waits for a free result register; a filtered
// candidate runs the shared distance unit, which squares one anchor's axis
// differences and then sums and keeps the minimum, anchor by anchor, then
// squares the radii and loads the decision. No new item is taken until then.
// Reset: synchronous, active low. Afterwards a clearing pass writes all 4096
// membership entries, one a cycle, with in_tready low; configuration writes
// are taken throughout.
// Stall: a finished result waits in the output register; the next item is
// taken meanwhile, and the block holds its next result until the register frees.
`timescale 1ns / 1ps
module distance_relevancy_hysteresis_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // client, sim_tick, entity, entity_found, has_position, pos_x, pos_y, pos_z
  input  logic [drhf_pkg::IN_DATA_W-1:0] in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // entity_out, include_res, unfiltered
  output logic [drhf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import drhf_pkg::*;

  drhf_cmd_t cmd;
  drhf_sts_t sts;

  drhf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  drhf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- sv/drhf_checker.sv -----
// Port-level checks for the relevancy filter, bound to the top level.
// Depends on drhf_pkg and distance_relevancy_hysteresis_filter.
`timescale 1ns / 1ps
module drhf_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [drhf_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // clearing pass blocks intake right after reset
  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("input taken during clearing pass");

  // a waiting result keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // an unfiltered result is always an inclusion
  a_unf_inc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[10])
    else $error("unfiltered result not included");

endmodule

bind distance_relevancy_hysteresis_filter drhf_assertions u_drhf_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/drhf_checker.sv -----
// Checker for the distance relevancy hysteresis filter: watches the input,
// output and configuration ports, predicts each decision and compares it.
// Depends on drhf_pkg.
`timescale 1ns / 1ps
module drhf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [drhf_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [drhf_pkg::OUT_DATA_W-1:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  import drhf_pkg::*;

  // packed from the top bit down, so entity lands in the lowest bits
  typedef struct packed {
    logic       unfiltered;
    logic       include_res;
    logic [9:0] entity;
  } decision_t;

  decision_t decision_q[$];

  logic signed [19:0] anc_x [MAX_ANCHORS];
  logic signed [19:0] anc_y [MAX_ANCHORS];
  logic signed [19:0] anc_z [MAX_ANCHORS];
  int unsigned        anc_num;
  logic [1:0]         cur_client;
  logic [31:0]        cur_tick;
  logic               member [MAX_CLIENTS*MAX_ENTITIES];
  logic [31:0]        since  [MAX_CLIENTS*MAX_ENTITIES];
  logic [19:0]        r_enter, r_exit;
  logic [15:0]        dwell;

  assign pending = decision_q.size();

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [63:0] axis_sq(input logic signed [19:0] a,
                                          input logic signed [19:0] b);
    logic signed [63:0] d;
    d = 64'(a) - 64'(b);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  // predict one input transfer
  task automatic predict(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
    logic [9:0]         ent;
    logic               found, has_pos;
    logic signed [19:0] px, py, pz;
    logic [63:0]        r_in, r_out, sq_dist, nearest;
    int                 slot;
    logic [31:0]        nxt;
    decision_t          dec;
    ent = d[43:34]; found = d[44]; has_pos = d[45];
    px = d[65:46]; py = d[85:66]; pz = d[105:86];
    case (op)
      OP_BEGIN: begin
        cur_client = d[1:0];
        cur_tick = d[33:2];
        anc_num = 0;
      end
      OP_ANCHOR: begin
        if (has_pos && anc_num < MAX_ANCHORS) begin
          anc_x[anc_num] = px; anc_y[anc_num] = py; anc_z[anc_num] = pz;
          anc_num++;
        end
      end
      OP_CAND: begin
        dec.entity = ent; dec.include_res = 1'b1; dec.unfiltered = 1'b1;
        if (anc_num == 0 || (found && !has_pos)) begin
          decision_q = {decision_q, dec};
        end else if (found) begin
          dec.unfiltered = 1'b0;
          r_in = (r_enter != 0) ? 64'(r_enter) : 64'(DEFAULT_RADIUS);
          r_out = 64'(r_exit);
          if (r_out <= r_in) r_out = r_in + r_in / 4;
          nearest = '1;
          for (int i = 0; i < anc_num; i++) begin
            sq_dist = axis_sq(px, anc_x[i]) + axis_sq(py, anc_y[i]) + axis_sq(pz, anc_z[i]);
            if (sq_dist < nearest) nearest = sq_dist;
          end
          slot = int'(cur_client) * MAX_ENTITIES + int'(ent);
          nxt = cur_tick + 32'd1;
          if (!member[slot]) begin
            if (nearest <= r_in * r_in) begin
              member[slot] = 1'b1; since[slot] = '0;
            end else begin
              dec.include_res = 1'b0;
            end
          end else if (nearest <= r_out * r_out) begin
            since[slot] = '0;
          end else if (since[slot] == 0) begin
            since[slot] = nxt;
          end else if (nxt - since[slot] >= 32'(dwell)) begin
            member[slot] = 1'b0; since[slot] = '0;
            dec.include_res = 1'b0;
          end
          decision_q = {decision_q, dec};
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    decision_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
      decision_q.delete();
      anc_num = 0; cur_client = '0; cur_tick = '0;
      r_enter = DEFAULT_RADIUS; r_exit = RESET_EXIT; dwell = RESET_DWELL;
      for (int i = 0; i < MAX_CLIENTS*MAX_ENTITIES; i++) begin
        member[i] = 1'b0; since[i] = '0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[11:0];
        if (decision_q.size() == 0) begin
          report($sformatf("unexpected result entity %0d", got.entity));
        end else begin
          want = decision_q.pop_front();
          if (got.entity != want.entity)
            report($sformatf("entity %0d, want %0d", got.entity, want.entity));
          if (got.include_res != want.include_res)
            report($sformatf("entity %0d include %0b, want %0b", want.entity,
                             got.include_res, want.include_res));
          if (got.unfiltered != want.unfiltered)
            report($sformatf("entity %0d unfiltered %0b, want %0b", want.entity,
                             got.unfiltered, want.unfiltered));
        end
      end
      if (in_tvalid && in_tready) predict(in_tuser, in_tdata);
      if (cfg_we) begin
        case (cfg_index)
          REG_ENTER: r_enter = cfg_wdata;
          REG_EXIT:  r_exit = cfg_wdata;
          REG_DWELL: dwell = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- tb/tb.sv -----
// Testbench top for the distance relevancy hysteresis filter: clock, reset,
// stimulus and verdict. Depends on drhf_pkg, the block and drhf_checker.
`timescale 1ns / 1ps
module tb;
  import drhf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ENTER;
  logic [19:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_BEGIN;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int          fail_count, pending;
  int          cycles = 0;
  int          sent = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  logic [31:0] tick_now = 32'd100;

  localparam int TOTAL = 1150;
  localparam int LIMIT = 400000;

  always #10 clk = ~clk;

  distance_relevancy_hysteresis_filter DUT (.*);

  drhf_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // valid stays high between back-to-back transfers; idle and drain drop it
  task automatic send(input logic [1:0] op, input logic [1:0] cli,
                      input logic [31:0] tk, input logic [9:0] ent,
                      input logic fnd, input logic hp,
                      input logic [19:0] x, input logic [19:0] y,
                      input logic [19:0] z);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tuser <= op;
    in_tdata <= {6'b0, z, y, x, hp, fnd, ent, tk, cli};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // coordinate near an anchor, at most span away from it
  function automatic logic [19:0] near(input logic [19:0] c, input int span);
    return c + 20'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  initial begin
    logic [19:0] ax, ay, az;
    logic [1:0]  cli;
    int          n, span;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: no anchors, then extremes, special cases
    send(OP_BEGIN, 2'd3, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send(OP_CAND, 0, 0, 10'd1023, 1'b0, 1'b0, 0, 0, 0);
    send(2'd3, 0, 0, 10'd5, 1, 1, 0, 0, 0);
    send(OP_ANCHOR, 0, 0, 0, 1, 1'b0, 20'h7FFFF, 0, 0);
    send(OP_ANCHOR, 0, 0, 0, 1, 1'b1, 20'h80000, 20'h80000, 20'h80000);
    send(OP_CAND, 0, 0, 10'd0, 1'b0, 1'b1, 0, 0, 0);
    send(OP_CAND, 0, 0, 10'd2, 1'b1, 1'b0, 0, 0, 0);
    send(OP_CAND, 0, 0, 10'd3, 1'b1, 1'b1, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    send(OP_CAND, 0, 0, 10'd4, 1'b1, 1'b1, 20'h80000, 20'h80000, 20'h80000);
    send(OP_ANCHOR, 0, 0, 0, 1, 1, 20'd0, 20'd0, 20'd0);
    send(OP_ANCHOR, 0, 0, 0, 1, 1, 20'd100, 20'd0, 20'd0);
    send(OP_ANCHOR, 0, 0, 0, 1, 1, 20'd0, 20'd200, 20'd0);
    send(OP_ANCHOR, 0, 0, 0, 1, 1, 20'd9, 20'd9, 20'd9);
    send(OP_CAND, 0, 0, 10'd4, 1'b1, 1'b1, 20'd4800, 20'd0, 20'd0);
    // member at tick max: clock does not start
    send(OP_CAND, 0, 0, 10'd4, 1'b1, 1'b1, 20'h7FFFF, 20'd0, 20'd0);
    send(OP_BEGIN, 2'd3, 32'd0, 0, 0, 0, 0, 0, 0);
    send(OP_ANCHOR, 0, 0, 0, 1, 1, 20'd0, 20'd0, 20'd0);
    send(OP_CAND, 0, 0, 10'd4, 1'b1, 1'b1, 20'h7FFFF, 20'd0, 20'd0);
    send(OP_CAND, 0, 0, 10'd4, 1'b1, 1'b1, 20'h7FFFF, 20'd0, 20'd0);
    drain();

    // random phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_ENTER, 20'd0); write_reg(REG_EXIT, 20'd0);
                 write_reg(REG_DWELL, 20'd0); end
        1: begin write_reg(REG_ENTER, 20'd2000); write_reg(REG_EXIT, 20'd3000);
                 write_reg(REG_DWELL, 20'd3); end
        2: begin write_reg(REG_ENTER, 20'hFFFFF); write_reg(REG_EXIT, 20'hFFFFF);
                 write_reg(REG_DWELL, 20'hFFFF); end
        3: begin write_reg(REG_ENTER, 20'd1); write_reg(REG_EXIT, 20'd1);
                 write_reg(REG_DWELL, 20'd1); end
        4: begin write_reg(REG_ENTER, 20'd3840); write_reg(REG_EXIT, 20'hFFFFF);
                 write_reg(REG_DWELL, 20'd2); end
        default: begin write_reg(REG_ENTER, 20'd500); write_reg(REG_EXIT, 20'd900);
                 write_reg(REG_DWELL, 20'd5); end
      endcase
      span = (ph == 3) ? 4 : (ph == 2) ? 600000 : 8000;
      while (sent < 25 + (ph + 1) * 188) begin
        if (ph == 5 && sent > TOTAL - 150) calm = 1'b1;
        if (ph == 3 && sent > 600 && sent < 603) hold_off = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          // noise: any op, any content
          send(2'($urandom), 2'($urandom), $urandom, 10'($urandom), 1'($urandom),
               1'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
          continue;
        end
        // well-formed query: begin, anchors, candidates
        cli = 2'($urandom);
        tick_now = ($urandom_range(0, 30) == 0) ? $urandom
                                                : tick_now + $urandom_range(1, 3);
        send(OP_BEGIN, cli, tick_now, 10'($urandom), 1'($urandom), 1'($urandom),
             20'($urandom), 20'($urandom), 20'($urandom));
        ax = 20'($urandom); ay = 20'($urandom); az = 20'($urandom);
        n = $urandom_range(0, 6);
        for (int a = 0; a < n; a++)
          send(OP_ANCHOR, 2'($urandom), $urandom, 10'($urandom), 1'($urandom),
               $urandom_range(0, 4) != 0, near(ax, span), near(ay, span),
               near(az, span));
        n = $urandom_range(1, 10);
        for (int c = 0; c < n; c++)
          send(OP_CAND, 2'($urandom), $urandom, 10'($urandom_range(0, 15)) +
               (($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'd0),
               $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
               near(ax, span), near(ay, span), near(az, span));
      end
      // sender pause until everything has come back
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/drhf_pkg.sv
sv/drhf_ctrl.sv
sv/drhf_dp.sv
sv/distance_relevancy_hysteresis_filter.sv
sv/drhf_checker.sv
tb/drhf_checker.sv
tb/tb.sv
